// ----- src/lbca_pkg.sv -----
// Shared codes, widths and types of the linked block chain allocator.
`default_nettype none

package lbca_pkg;

	// Default table depth in blocks.
	localparam int DISK_BLOCKS_DEF = 256;

	// Widths of the block count, of a block number and of an entry kind.
	localparam int CNT_W  = 9;
	localparam int BLK_W  = 8;
	localparam int KIND_W = 2;

	// Request codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// Table entry kinds.
	localparam logic [KIND_W-1:0] KIND_FREE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LINK = 2'd2;

	// One table entry.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BLK_W-1:0]  next;
	} entry_t;

endpackage

`default_nettype wire

// ----- src/linked_block_chain_allocator.sv -----
// Top level of the linked block chain allocator: table memory, sequencer and result registers.
//
// A request is taken when start is high and busy is low; its result appears on the result
// ports for exactly one cycle with done high, and the receiver cannot hold it off. A read
// goes through one registered table read, a rejected request is answered from idle, and
// an allocation of N blocks writes N entries, as the chain walker writes one table entry per
// cycle through the single write port of the table memory. Blocks are never released, so
// the allocated blocks always form a prefix of the table; a fill count marks that prefix and
// every entry above it reads as free, which is why reset and a disk_blocks write take effect
// at once without a clearing pass. The configuration channel is ready whenever the block is
// idle and no request is offered on start; a write clears the table and reloads the free
// count.
`default_nettype none

module linked_block_chain_allocator #(
	parameter int DISK_BLOCKS = lbca_pkg::DISK_BLOCKS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// Request channel.
	input  wire                            start,
	output logic                           busy,
	input  wire                            op,
	input  wire  [lbca_pkg::CNT_W-1:0]     request_size,
	input  wire  [lbca_pkg::BLK_W-1:0]     entry_index,
	// Configuration channel.
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [lbca_pkg::CNT_W-1:0]     cfg_data,
	// Result channel.
	output logic                           done,
	output logic [1:0]                     status,
	output logic [lbca_pkg::BLK_W-1:0]     start_block,
	output logic [lbca_pkg::BLK_W-1:0]     end_block,
	output logic [lbca_pkg::KIND_W-1:0]    entry_kind,
	output logic [lbca_pkg::BLK_W-1:0]     entry_next,
	output logic [lbca_pkg::CNT_W-1:0]     free_left
);

	localparam int ADDR_W = $clog2(DISK_BLOCKS);
	localparam int CNT_W  = lbca_pkg::CNT_W;
	localparam int BLK_W  = lbca_pkg::BLK_W;

	// Largest block count a register write can set (the table depth, at most 511), and the reset value (at most 256).
	localparam logic [CNT_W-1:0] BLK_MAX = (DISK_BLOCKS > 511) ? 9'd511 : CNT_W'(DISK_BLOCKS);
	localparam logic [CNT_W-1:0] BLK_RST = (DISK_BLOCKS > 256) ? 9'd256 : CNT_W'(DISK_BLOCKS);

	typedef enum logic [2:0] {
		FSM_IDLE  = 3'b001,
		FSM_ALLOC = 3'b010,
		FSM_READ  = 3'b100
	} fsm_t;

	fsm_t                      state_q;
	logic                      done_q;
	logic [CNT_W-1:0]          disk_blocks_q;
	logic [CNT_W-1:0]          free_q;
	logic [CNT_W-1:0]          used_q;

	logic [CNT_W-1:0]          ptr_q;
	logic [CNT_W-1:0]          left_q;
	logic [CNT_W-1:0]          size_q;
	logic [BLK_W-1:0]          start_q;
	logic                      hit_q;

	logic [1:0]                status_q;
	logic [BLK_W-1:0]          start_block_q;
	logic [BLK_W-1:0]          end_block_q;
	logic [lbca_pkg::KIND_W-1:0] entry_kind_q;
	logic [BLK_W-1:0]          entry_next_q;
	logic [CNT_W-1:0]          free_left_q;

	lbca_pkg::entry_t          table_q [DISK_BLOCKS];
	lbca_pkg::entry_t          rd_q;
	lbca_pkg::entry_t          wr_entry;

	logic                      accept;
	logic                      last_blk;
	logic                      size_zero;
	logic                      size_big;
	logic                      idx_out;
	logic [CNT_W-1:0]          ptr_inc;
	logic [CNT_W-1:0]          cfg_clamped;

	// Handshake decode. A request offered on start wins over a register write.
	assign busy      = (state_q != FSM_IDLE);
	assign cfg_ready = (state_q == FSM_IDLE) && !start;
	assign accept    = start && !busy;

	// Request checks made as the request is taken.
	assign size_zero = (request_size == '0);
	assign size_big  = (request_size > free_q);
	assign idx_out   = ({1'b0, entry_index} >= disk_blocks_q);

	// The chain walker: one entry per cycle, the last one closes the chain.
	assign last_blk = (left_q == CNT_W'(1));
	assign ptr_inc  = ptr_q + CNT_W'(1);
	always_comb begin
		wr_entry.kind = last_blk ? lbca_pkg::KIND_END : lbca_pkg::KIND_LINK;
		wr_entry.next = last_blk ? '0 : ptr_inc[BLK_W-1:0];
	end

	// Register writes are limited to the range the table supports.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamped = CNT_W'(1);
		end else if (cfg_data > BLK_MAX) begin
			cfg_clamped = BLK_MAX;
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	// Sequencer and block counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= FSM_IDLE;
			done_q        <= 1'b0;
			disk_blocks_q <= BLK_RST;
			free_q        <= BLK_RST;
			used_q        <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				FSM_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						disk_blocks_q <= cfg_clamped;
						free_q        <= cfg_clamped;
						used_q        <= '0;
					end else if (accept) begin
						if (op == lbca_pkg::OP_ALLOC) begin
							if (size_zero || size_big) begin
								done_q <= 1'b1;
							end else begin
								state_q <= FSM_ALLOC;
							end
						end else begin
							if (idx_out) begin
								done_q <= 1'b1;
							end else begin
								state_q <= FSM_READ;
							end
						end
					end
				end
				FSM_ALLOC: begin
					if (last_blk) begin
						state_q <= FSM_IDLE;
						done_q  <= 1'b1;
						free_q  <= free_q - size_q;
						used_q  <= used_q + size_q;
					end
				end
				FSM_READ: begin
					state_q <= FSM_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	// Walker registers and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					ptr_q         <= used_q;
					left_q        <= request_size;
					size_q        <= request_size;
					start_q       <= used_q[BLK_W-1:0];
					hit_q         <= ({1'b0, entry_index} < used_q);
					start_block_q <= '0;
					end_block_q   <= '0;
					entry_kind_q  <= lbca_pkg::KIND_FREE;
					entry_next_q  <= '0;
					free_left_q   <= free_q;
					if (op == lbca_pkg::OP_ALLOC) begin
						status_q <= size_zero ? lbca_pkg::ST_ZERO : lbca_pkg::ST_SHORT;
					end else begin
						status_q <= lbca_pkg::ST_RANGE;
					end
				end
			end
			FSM_ALLOC: begin
				ptr_q  <= ptr_inc;
				left_q <= left_q - CNT_W'(1);
				if (last_blk) begin
					status_q      <= lbca_pkg::ST_OK;
					start_block_q <= start_q;
					end_block_q   <= ptr_q[BLK_W-1:0];
					entry_kind_q  <= lbca_pkg::KIND_FREE;
					entry_next_q  <= '0;
					free_left_q   <= free_q - size_q;
				end
			end
			FSM_READ: begin
				status_q      <= lbca_pkg::ST_OK;
				start_block_q <= '0;
				end_block_q   <= '0;
				free_left_q   <= free_q;
				// Entries above the allocated prefix are free.
				entry_kind_q  <= hit_q ? rd_q.kind : lbca_pkg::KIND_FREE;
				entry_next_q  <= (hit_q && rd_q.kind == lbca_pkg::KIND_LINK) ? rd_q.next : '0;
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	// Table memory: one write port for the walker, one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == FSM_ALLOC) begin
			table_q[ADDR_W'(ptr_q)] <= wr_entry;
		end
		if (accept) begin
			rd_q <= table_q[ADDR_W'(entry_index)];
		end
	end

	// Result ports.
	assign done        = done_q;
	assign status      = status_q;
	assign start_block = start_block_q;
	assign end_block   = end_block_q;
	assign entry_kind  = entry_kind_q;
	assign entry_next  = entry_next_q;
	assign free_left   = free_left_q;

endmodule

`default_nettype wire

// ----- src/lbca_checker.sv -----
// Port-level assertions for the linked block chain allocator, bound to the top level.
`default_nettype none

module lbca_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          start,
	input wire                          busy,
	input wire                          op,
	input wire [lbca_pkg::CNT_W-1:0]    request_size,
	input wire                          done,
	input wire [1:0]                    status,
	input wire [lbca_pkg::BLK_W-1:0]    start_block,
	input wire [lbca_pkg::BLK_W-1:0]    end_block,
	input wire [lbca_pkg::KIND_W-1:0]   entry_kind,
	input wire [lbca_pkg::BLK_W-1:0]    entry_next
);

	// A result is only shown once the sequencer has gone back to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// A rejected request leaves every unused result field at zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != lbca_pkg::ST_OK) |->
			(start_block == '0 && end_block == '0 &&
			 entry_kind == lbca_pkg::KIND_FREE && entry_next == '0))
		else $error("rejected request with nonzero fields");

	// An allocation of zero blocks is rejected in the very next cycle.
	a_zero_size: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == lbca_pkg::OP_ALLOC && request_size == '0) |=>
			(done && status == lbca_pkg::ST_ZERO))
		else $error("zero size request not rejected");

endmodule

bind linked_block_chain_allocator lbca_checker u_lbca_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.op           (op),
	.request_size (request_size),
	.done         (done),
	.status       (status),
	.start_block  (start_block),
	.end_block    (end_block),
	.entry_kind   (entry_kind),
	.entry_next   (entry_next)
);

`default_nettype wire
